@@ rtl/tcw_pkg.sv @@
package tcw_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam int CELL_W      = 16;
  localparam int CHAR_W      = 8;
  localparam int STORE_DEPTH = 2048;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int LIN_W       = 12;
  localparam int COL_W       = 7;
  localparam int ROW_W       = 5;

  localparam logic [1:0] OP_PUT    = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_CENTER = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CHAR_BLANK     = 8'd32;

  localparam logic [7:0] COLOR_RESET = 8'd7;

  typedef struct packed {
    logic [1:0]        op;
    logic [CHAR_W-1:0] char_code;
    logic [7:0]        text_length;
    logic [ADDR_W-1:0] cell_index;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] cursor_pos;
    logic [CELL_W-1:0] cell_value;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL_RD,
    ST_SCROLL_WR,
    ST_FILL,
    ST_CLEAR,
    ST_READ_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic scroll_rd;
    logic scroll_wr;
    logic fill;
    logic clear;
    logic read_cap;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       scroll;
    logic       copy_last;
    logic       cell_last;
  } stat_t;

endpackage

@@ rtl/tcw_ram.sv @@
module tcw_ram import tcw_pkg::*; #(
  parameter int WIDTH = CELL_W,
  parameter int DEPTH = STORE_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/tcw_ctrl.sv @@
module tcw_ctrl import tcw_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;
  logic   slot_free;

  assign slot_free = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        case (stat.op)
          OP_PUT:    state_next = stat.scroll ? ST_SCROLL_RD : ST_FINISH;
          OP_CLEAR:  state_next = ST_CLEAR;
          OP_CENTER: state_next = ST_FINISH;
          OP_READ:   state_next = ST_READ_WAIT;
          default:   state_next = ST_FINISH;
        endcase
      end
      ST_SCROLL_RD: begin
        cmd.scroll_rd = 1'b1;
        state_next    = ST_SCROLL_WR;
      end
      ST_SCROLL_WR: begin
        cmd.scroll_wr = 1'b1;
        state_next    = stat.copy_last ? ST_FILL : ST_SCROLL_RD;
      end
      ST_FILL: begin
        cmd.fill = 1'b1;
        if (stat.cell_last) state_next = ST_FINISH;
      end
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.cell_last) state_next = ST_FINISH;
      end
      ST_READ_WAIT: begin
        cmd.read_cap = 1'b1;
        state_next   = ST_FINISH;
      end
      ST_FINISH: begin
        // hold the result until the output register frees up
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/tcw_dp.sv @@
module tcw_dp import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  input  in_t        in_data,
  output out_t       out_data,
  input  cmd_t       cmd,
  output stat_t      stat
);

  localparam logic [LIN_W-1:0] LIN_COLS   = LIN_W'(COLUMNS);
  localparam logic [LIN_W-1:0] COPY_LAST  = LIN_W'((ROWS - 1) * COLUMNS - 1);
  localparam logic [LIN_W-1:0] CELLS_LAST = LIN_W'(ROWS * COLUMNS - 1);
  localparam logic [COL_W-1:0] COL_LAST   = COL_W'(COLUMNS - 1);
  localparam logic [COL_W:0]   COL_END    = (COL_W + 1)'(COLUMNS);
  localparam logic [ROW_W-1:0] ROW_END    = ROW_W'(ROWS);
  localparam logic [ROW_W-1:0] ROW_LAST   = ROW_W'(ROWS - 1);
  localparam logic [7:0]       LEN_END    = 8'(COLUMNS);

  function automatic logic [LIN_W-1:0] lin_of(input logic [ROW_W-1:0] r,
                                               input logic [COL_W-1:0] c);
    return LIN_W'(r) * LIN_COLS + LIN_W'(c);
  endfunction

  in_t               item;
  logic [7:0]        color;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [LIN_W-1:0]  lin;
  logic [CELL_W-1:0] value;

  logic [COL_W-1:0]  col_next;
  logic [ROW_W-1:0]  row_next;
  logic [COL_W:0]    col_inc;
  logic              is_nl, is_bs;
  logic [LIN_W-1:0]  put_lin, cur_lin, src_lin;
  logic [7:0]        center_w;

  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [CELL_W-1:0] wdata, rdata;

  assign is_nl   = (item.char_code == CHAR_NEWLINE);
  assign is_bs   = (item.char_code == CHAR_BACKSPACE);
  assign col_inc = {1'b0, col} + 1'b1;
  assign src_lin = lin + LIN_COLS;
  assign cur_lin = lin_of(row, col);
  assign center_w = (LEN_END - item.text_length) >> 1;

  // cursor motion of a put
  always_comb begin
    col_next = col;
    row_next = row;
    if (is_nl) begin
      col_next = '0;
      row_next = row + 1'b1;
    end else if (is_bs) begin
      if (col != '0) begin
        col_next = col - 1'b1;
      end else if (row != '0) begin
        row_next = row - 1'b1;
        col_next = COL_LAST;
      end
    end else if (col_inc == COL_END) begin
      col_next = '0;
      row_next = row + 1'b1;
    end else begin
      col_next = col_inc[COL_W-1:0];
    end
  end

  // backspace blanks the cell it lands on, a printable byte goes at the old cursor
  assign put_lin = is_bs ? lin_of(row_next, col_next) : cur_lin;

  assign stat.op        = item.op;
  assign stat.scroll    = (row_next >= ROW_END);
  assign stat.copy_last = (lin == COPY_LAST);
  assign stat.cell_last = (lin == CELLS_LAST);

  always_comb begin
    we    = 1'b0;
    waddr = lin[ADDR_W-1:0];
    wdata = {color, CHAR_BLANK};
    raddr = item.cell_index;
    if (cmd.exec && item.op == OP_PUT && !is_nl) begin
      we    = 1'b1;
      waddr = put_lin[ADDR_W-1:0];
      wdata = {color, is_bs ? CHAR_BLANK : item.char_code};
    end
    if (cmd.scroll_rd) begin
      raddr = src_lin[ADDR_W-1:0];
    end
    if (cmd.scroll_wr) begin
      we    = 1'b1;
      wdata = rdata;
    end
    if (cmd.fill || cmd.clear) begin
      we = 1'b1;
    end
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (STORE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      color <= COLOR_RESET;
      col   <= '0;
      row   <= '0;
    end else begin
      if (cfg_write) begin
        color <= cfg_data;
      end
      if (cmd.exec) begin
        case (item.op)
          OP_PUT: begin
            col <= col_next;
            row <= stat.scroll ? ROW_LAST : row_next;
          end
          OP_CLEAR: begin
            col <= '0;
            row <= '0;
          end
          OP_CENTER: begin
            if (item.text_length < LEN_END) col <= center_w[COL_W-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item <= in_data;
    end
    if (cmd.exec) begin
      lin   <= '0;
      value <= '0;
    end
    if (cmd.scroll_wr || cmd.fill || cmd.clear) begin
      lin <= lin + 1'b1;
    end
    if (cmd.read_cap) begin
      value <= rdata;
    end
    if (cmd.load_out) begin
      out_data.cursor_pos <= cur_lin[ADDR_W-1:0];
      out_data.cell_value <= value;
    end
  end

endmodule

@@ rtl/text_console_writer.sv @@
// Text-mode console writer with a cursor and a 2048-cell screen store.
// Input channel (in_valid/in_stall/in_data) takes one operation per
// transaction: put character, clear, center for a length, or read a cell.
// Output channel (out_valid/out_stall/out_data) returns one transaction per
// operation: the cursor position after it, and for a read the cell value.
// cfg_write/cfg_data set the attribute byte used for every cell written by a
// put, a clear or the bottom-row fill; scrolled cells keep their attribute.
// From acceptance, put and centre pass ST_EXEC and ST_FINISH, and read adds
// ST_READ_WAIT (registered RAM read), before the result loads the output
// register. A put that scrolls copies each cell one row up through the RAM's
// single read port in a read state and then a write state, then the bottom
// row is blanked one cell a cycle. Clear blanks every screen cell.
// One operation is in flight at a time; the next is accepted while a result
// still waits in the output register. A stalled result holds, and the
// controller waits before loading the next one.
// Reset homes the cursor, sets the attribute to 7 and leaves the store as is.
module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_t        in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_t       out_data
);

  cmd_t  cmd;
  stat_t stat;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  tcw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
